// File: sv/assert_macros.svh
// assertion macros shared by the stack/queue engine rtl
// expects a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge, off while reset is held
`define SQE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// invariant that must hold at every rising clock edge out of reset
`define SQE_ASSERT_ALWAYS(label, expr, msg) \
    `SQE_ASSERT(label, 1'b1 |-> (expr), msg)

`endif

// File: sv/sqe_pkg.sv
// types and codes for the stack/queue engine
// used by sqe_cell and stack_queue_engine_core; no dependencies
package sqe_pkg;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_DUMP = 2'd3
    } t_opcode;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_POP_EMPTY  = 3'd1;
    localparam logic [2:0] ST_PEEK_EMPTY = 3'd2;
    localparam logic [2:0] ST_PUSH_FULL  = 3'd3;
    localparam logic [2:0] ST_DUMP_EMPTY = 3'd4;

    typedef struct packed {
        t_opcode            opcode;
        logic signed [31:0] push_value;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] data_value;
        logic [2:0]         status_code;
        logic               data_valid;
        logic               last_of_run;
    } t_result;

    // per-cycle move applied along the cell chain
    typedef struct packed {
        logic shift_dn;  // stack push: everything moves one place toward the tail
        logic shift_up;  // pop: everything moves one place toward the top
        logic rotate;    // dump step: top goes to the tail, rest move up
        logic append;    // queue push: the cell at the fill point takes the value
    } t_cell_ctl;

endpackage

// File: sv/stack_queue_engine_core.sv
// stack/queue engine top level: control, fill count and the row of cells
// depends on sqe_pkg, sqe_cell and assert_macros.svh
//
// usage:
//   commands come in on i_cmd and are taken at a rising edge with start high
//   and busy low. every command gives one or more result beats on o_result,
//   each marked by o_strobe for exactly one cycle; the receiver cannot stall.
//   the values live in a chain of DEPTH cells ordered top to tail, so the
//   top is always cell 0. push, pop and peek move or read the chain in the
//   accepting cycle and show their single result beat on the next cycle;
//   busy stays low, so one such command per cycle is taken.
//   a dump of n values rotates the chain once per cycle and gives one beat per
//   value, the first registered at acceptance, last_of_run on the tail value;
//   busy stays high until the last beat is sent (low for one value or none).
//   i_cfg_we writes queue_mode from i_cfg_wdata; only later pushes follow it.
//   reset (synchronous, active low) empties the store, clears queue_mode
//   and drops busy and o_strobe; cell contents are not cleared.
module stack_queue_engine_core #(
    parameter int DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  sqe_pkg::t_cmd     i_cmd,
    output logic              busy,
    output logic              o_strobe,
    output sqe_pkg::t_result  o_result,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata
);

    `include "assert_macros.svh"

    localparam int            CW      = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic {S_IDLE, S_DUMP} t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_left;
    logic               r_mode;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic [CW-1:0]      w_tail;
    sqe_pkg::t_cell_ctl w_ctl;
    logic signed [31:0] w_val [DEPTH];

    assign w_accept = start && !busy;
    assign w_full   = (r_count == DEPTH_C);
    assign w_empty  = (r_count == '0);
    assign w_tail   = r_count - ONE_C;

    always_comb begin
        w_ctl.shift_dn = w_accept && (i_cmd.opcode == sqe_pkg::OP_PUSH) && !w_full && !r_mode;
        w_ctl.append   = w_accept && (i_cmd.opcode == sqe_pkg::OP_PUSH) && !w_full && r_mode;
        w_ctl.shift_up = w_accept && (i_cmd.opcode == sqe_pkg::OP_POP) && !w_empty;
        w_ctl.rotate   = (w_accept && (i_cmd.opcode == sqe_pkg::OP_DUMP) && !w_empty)
                         || (r_state == S_DUMP);
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            sqe_cell #(
                .DEPTH (DEPTH),
                .IDX   (gi)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_count      (r_count),
                .i_tail       (w_tail),
                .i_push_value (i_cmd.push_value),
                .i_prev       (w_val[(gi == 0) ? 0 : gi - 1]),
                .i_next       (w_val[(gi == DEPTH - 1) ? DEPTH - 1 : gi + 1]),
                .i_head       (w_val[0]),
                .o_value      (w_val[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_mode   <= 1'b0;
            busy     <= 1'b0;
            o_strobe <= 1'b0;
            o_result <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        o_strobe             <= 1'b1;
                        o_result.data_value  <= '0;
                        o_result.status_code <= sqe_pkg::ST_OK;
                        o_result.data_valid  <= 1'b0;
                        o_result.last_of_run <= 1'b1;
                        unique case (i_cmd.opcode)
                            sqe_pkg::OP_PUSH: begin
                                if (w_full) begin
                                    o_result.status_code <= sqe_pkg::ST_PUSH_FULL;
                                end else begin
                                    r_count <= r_count + ONE_C;
                                end
                            end
                            sqe_pkg::OP_POP: begin
                                if (w_empty) begin
                                    o_result.status_code <= sqe_pkg::ST_POP_EMPTY;
                                end else begin
                                    r_count <= r_count - ONE_C;
                                end
                            end
                            sqe_pkg::OP_PEEK: begin
                                if (w_empty) begin
                                    o_result.status_code <= sqe_pkg::ST_PEEK_EMPTY;
                                end else begin
                                    o_result.data_value <= w_val[0];
                                    o_result.data_valid <= 1'b1;
                                end
                            end
                            sqe_pkg::OP_DUMP: begin
                                if (w_empty) begin
                                    o_result.status_code <= sqe_pkg::ST_DUMP_EMPTY;
                                end else begin
                                    // first beat goes out now, the rest from S_DUMP
                                    o_result.data_value  <= w_val[0];
                                    o_result.data_valid  <= 1'b1;
                                    o_result.last_of_run <= (r_count == ONE_C);
                                    r_left               <= w_tail;
                                    if (r_count != ONE_C) begin
                                        r_state <= S_DUMP;
                                        busy    <= 1'b1;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DUMP: begin
                    o_strobe             <= 1'b1;
                    o_result.data_value  <= w_val[0];
                    o_result.status_code <= sqe_pkg::ST_OK;
                    o_result.data_valid  <= 1'b1;
                    o_result.last_of_run <= (r_left == ONE_C);
                    r_left               <= r_left - ONE_C;
                    if (r_left == ONE_C) begin
                        r_state <= S_IDLE;
                        busy    <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    busy    <= 1'b0;
                end
            endcase
        end
    end

    `SQE_ASSERT_ALWAYS(a_count_bound, r_count <= DEPTH_C, "fill count above depth")
    `SQE_ASSERT_ALWAYS(a_dump_left, (r_state != S_DUMP) || (r_left != '0),
        "dump running with no beats left")
    `SQE_ASSERT(a_valid_ok, o_strobe && o_result.data_valid |->
        o_result.status_code == sqe_pkg::ST_OK, "data beat with error status")
    `SQE_ASSERT(a_push_full, w_accept && (i_cmd.opcode == sqe_pkg::OP_PUSH) && w_full |=>
        o_strobe && (o_result.status_code == sqe_pkg::ST_PUSH_FULL) && $stable(r_count),
        "push on full store not rejected")
    `SQE_ASSERT(a_last_idle, o_strobe && o_result.last_of_run |-> !busy,
        "busy still high after the last beat")

endmodule

// File: sv/sqe_cell.sv
// one storage cell of the stack/queue chain, position IDX from the top
// depends on sqe_pkg for the chain control struct
module sqe_cell #(
    parameter int DEPTH = 64,
    parameter int IDX   = 0
) (
    input  logic                         i_clk,
    input  sqe_pkg::t_cell_ctl           i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]   i_count,
    input  logic [$clog2(DEPTH+1)-1:0]   i_tail,
    input  logic signed [31:0]           i_push_value,
    input  logic signed [31:0]           i_prev,
    input  logic signed [31:0]           i_next,
    input  logic signed [31:0]           i_head,
    output logic signed [31:0]           o_value
);

    localparam int             CW    = $clog2(DEPTH + 1);
    localparam logic [CW-1:0]  IDX_C = CW'(IDX);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.shift_dn) begin
            n_value = (IDX == 0) ? i_push_value : i_prev;
        end else if (i_ctl.shift_up) begin
            n_value = i_next;
        end else if (i_ctl.rotate) begin
            n_value = (i_tail == IDX_C) ? i_head : i_next;
        end else if (i_ctl.append && (i_count == IDX_C)) begin
            n_value = i_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// File: tb/stack_queue_engine_core_tb.sv
// self-checking testbench for stack_queue_engine_core: command beats in, result beats out
// depends on sqe_pkg and the core rtl; results are predicted by a shadow store in this file
`timescale 1ns / 100ps

module stack_queue_engine_core_tb;

    localparam int DEPTH = 64;
    localparam int STALL_LIMIT = 1000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    sqe_pkg::t_cmd    cmd_beat;
    logic             busy;
    logic             result_strobe;
    sqe_pkg::t_result result_beat;
    logic             cfg_we;
    logic             cfg_wdata;

    // shadow of the store, top at index 0, plus the mode register
    logic signed [31:0] held_values[$];
    logic               shadow_queue_mode;
    sqe_pkg::t_result   pending_results[$];
    sqe_pkg::t_result   want_result;

    int unsigned idle_pct;
    int unsigned mismatch_count;
    int unsigned stall_cycles;

    stack_queue_engine_core #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_cmd      (cmd_beat),
        .busy       (busy),
        .o_strobe   (result_strobe),
        .o_result   (result_beat),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %0s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // expected result beats for one accepted command
    task automatic predict_cmd(input sqe_pkg::t_opcode op, input logic signed [31:0] v);
        sqe_pkg::t_result r;
        r = '0;
        r.last_of_run = 1'b1;
        case (op)
            sqe_pkg::OP_PUSH: begin
                if (held_values.size() >= DEPTH)
                    r.status_code = sqe_pkg::ST_PUSH_FULL;
                else if (shadow_queue_mode)
                    held_values.push_back(v);
                else
                    held_values.push_front(v);
                pending_results.push_back(r);
            end
            sqe_pkg::OP_POP: begin
                if (held_values.size() == 0)
                    r.status_code = sqe_pkg::ST_POP_EMPTY;
                else
                    void'(held_values.pop_front());
                pending_results.push_back(r);
            end
            sqe_pkg::OP_PEEK: begin
                if (held_values.size() == 0) begin
                    r.status_code = sqe_pkg::ST_PEEK_EMPTY;
                end else begin
                    r.data_value = held_values[0];
                    r.data_valid = 1'b1;
                end
                pending_results.push_back(r);
            end
            default: begin
                if (held_values.size() == 0) begin
                    r.status_code = sqe_pkg::ST_DUMP_EMPTY;
                    pending_results.push_back(r);
                end else begin
                    foreach (held_values[k]) begin
                        r.data_value  = held_values[k];
                        r.data_valid  = 1'b1;
                        r.last_of_run = (k == held_values.size() - 1);
                        pending_results.push_back(r);
                    end
                end
            end
        endcase
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic hold_idle(input int unsigned n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // one command beat; start is left high so back-to-back beats need no gap
    task automatic send_cmd(input sqe_pkg::t_opcode op, input logic signed [31:0] v);
        // each idle cycle is drawn on its own, so idle_pct is the share of idle cycles
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
            hold_idle(1);
        @(negedge i_clk);
        start    <= 1'b1;
        cmd_beat <= sqe_pkg::t_cmd'{op, v};
        do @(posedge i_clk); while (busy);
        predict_cmd(op, v);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        wait_drained();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        shadow_queue_mode = mode;
        @(posedge i_clk);
    endtask

    task automatic test_empty_store();
        send_cmd(sqe_pkg::OP_POP, 32'h7fff_ffff);
        send_cmd(sqe_pkg::OP_PEEK, 32'h8000_0000);
        send_cmd(sqe_pkg::OP_DUMP, 32'hffff_ffff);
    endtask

    task automatic test_stack_extremes();
        send_cmd(sqe_pkg::OP_PUSH, 32'h8000_0000);
        send_cmd(sqe_pkg::OP_PUSH, 32'h7fff_ffff);
        send_cmd(sqe_pkg::OP_PUSH, 32'h0000_0000);
        send_cmd(sqe_pkg::OP_PUSH, 32'hffff_ffff);
        send_cmd(sqe_pkg::OP_PEEK, 32'h0);
        send_cmd(sqe_pkg::OP_DUMP, 32'h0);
        send_cmd(sqe_pkg::OP_POP, 32'h0);
        send_cmd(sqe_pkg::OP_PEEK, 32'h0);
    endtask

    // contents keep their order across the switch, new pushes go to the tail
    task automatic test_mode_switch();
        write_mode(1'b1);
        send_cmd(sqe_pkg::OP_PUSH, 32'h1234_5678);
        send_cmd(sqe_pkg::OP_PUSH, 32'h5a5a_a5a5);
        send_cmd(sqe_pkg::OP_DUMP, 32'h0);
        repeat (6) send_cmd(sqe_pkg::OP_POP, 32'h0);
        send_cmd(sqe_pkg::OP_PEEK, 32'h0);
        send_cmd(sqe_pkg::OP_DUMP, 32'h0);
    endtask

    task automatic test_full_store();
        write_mode(1'b0);
        idle_pct = 24;
        repeat (DEPTH) send_cmd(sqe_pkg::OP_PUSH, pick_value());
        send_cmd(sqe_pkg::OP_PUSH, pick_value());
        send_cmd(sqe_pkg::OP_PUSH, pick_value());
        send_cmd(sqe_pkg::OP_DUMP, 32'h0);
        send_cmd(sqe_pkg::OP_PEEK, 32'h0);
        write_mode(1'b1);
        send_cmd(sqe_pkg::OP_PUSH, pick_value());
        // free three entries, then refill them at the tail in queue mode
        repeat (3) send_cmd(sqe_pkg::OP_POP, 32'h0);
        repeat (3) send_cmd(sqe_pkg::OP_PUSH, pick_value());
        send_cmd(sqe_pkg::OP_DUMP, 32'h0);
        while (held_values.size() != 0)
            send_cmd(($urandom_range(4) == 0) ? sqe_pkg::OP_PEEK : sqe_pkg::OP_POP,
                     pick_value());
    endtask

    task automatic run_random_phase(input int unsigned n_items, input int unsigned push_pct,
                                    input int unsigned pop_pct);
        sqe_pkg::t_opcode op;
        int unsigned      roll;
        for (int unsigned i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            if (roll < push_pct)
                op = sqe_pkg::OP_PUSH;
            else if (roll < push_pct + pop_pct)
                op = sqe_pkg::OP_POP;
            else if (roll[0])
                op = sqe_pkg::OP_PEEK;
            else
                op = sqe_pkg::OP_DUMP;
            send_cmd(op, pick_value());
            if ($urandom_range(99) < 3)
                wait_drained();
        end
    endtask

    task automatic test_random_traffic();
        write_mode(1'b0);
        idle_pct = 0;
        run_random_phase(45, 55, 25);
        write_mode(1'b1);
        idle_pct = 51;
        run_random_phase(45, 40, 40);
        write_mode(1'b0);
        idle_pct = 24;
        run_random_phase(45, 60, 20);
    endtask

    // result checker: every strobed beat is matched against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && result_strobe) begin
            if (pending_results.size() == 0) begin
                report_mismatch("beat with nothing expected", result_beat.data_value, 32'h0);
            end else begin
                want_result = pending_results.pop_front();
                if (result_beat.data_value !== want_result.data_value)
                    report_mismatch("data_value", result_beat.data_value,
                                    want_result.data_value);
                if (result_beat.status_code !== want_result.status_code)
                    report_mismatch("status_code", 32'(result_beat.status_code),
                                    32'(want_result.status_code));
                if (result_beat.data_valid !== want_result.data_valid)
                    report_mismatch("data_valid", 32'(result_beat.data_valid),
                                    32'(want_result.data_valid));
                if (result_beat.last_of_run !== want_result.last_of_run)
                    report_mismatch("last_of_run", 32'(result_beat.last_of_run),
                                    32'(want_result.last_of_run));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || result_strobe)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("** stack_queue_engine_core: FAILED **");
            $finish;
        end
    end

    initial begin
        start             = 1'b0;
        cmd_beat          = '0;
        cfg_we            = 1'b0;
        cfg_wdata         = 1'b0;
        i_rst_n           = 1'b0;
        shadow_queue_mode = 1'b0;
        idle_pct          = 0;
        mismatch_count    = 0;
        stall_cycles      = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_store();
        test_stack_extremes();
        test_mode_switch();
        test_full_store();
        test_random_traffic();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("** stack_queue_engine_core: PASSED **");
        else
            $display("** stack_queue_engine_core: FAILED **");
        $finish;
    end

endmodule

// File: stack_queue_engine_core.f
+incdir+sv
sv/sqe_pkg.sv
sv/sqe_cell.sv
sv/stack_queue_engine_core.sv
tb/stack_queue_engine_core_tb.sv
